>>> hw/rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared sizes, codes and the entry record of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_POPS    = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef logic [2:0]  func_t;
  typedef logic [2:0]  status_t;
  typedef logic [31:0] qtime_t;
  typedef logic [31:0] seq_t;
  typedef logic [15:0] tag_t;
  typedef logic [4:0]  removed_t;

  localparam func_t FN_POST       = 3'd0;
  localparam func_t FN_CANCEL_ID  = 3'd1;
  localparam func_t FN_CANCEL_OBJ = 3'd2;
  localparam func_t FN_QUERY      = 3'd3;
  localparam func_t FN_ADVANCE    = 3'd4;
  localparam func_t FN_EXEC       = 3'd5;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_FULL       = 3'd1;
  localparam status_t ST_NOT_FOUND  = 3'd2;
  localparam status_t ST_PAST       = 3'd3;
  localparam status_t ST_NONE_READY = 3'd4;

  typedef struct packed {
    qtime_t due;
    qtime_t start;
    seq_t   seq;
    tag_t   object;
    tag_t   payload;
    logic   ready;
  } entry_t;

endpackage

>>> hw/rtl/teq_if.sv
// ----------------------------------------------------------------------------
// teq_if
// Command and response channels of the timed event queue.
// ----------------------------------------------------------------------------
interface teq_cmd_if;
  logic             valid;
  logic             ready;
  teq_pkg::func_t   func;
  teq_pkg::qtime_t  time_value;
  teq_pkg::seq_t    event_id;
  teq_pkg::tag_t    object_id;
  teq_pkg::tag_t    payload_handle;

  modport source (output valid, func, time_value, event_id, object_id, payload_handle,
                  input ready);
  modport sink (input valid, func, time_value, event_id, object_id, payload_handle,
                output ready);
endinterface

interface teq_rsp_if;
  logic               valid;
  logic               ready;
  teq_pkg::status_t   status;
  teq_pkg::seq_t      result_id;
  logic               pending;
  teq_pkg::qtime_t    time_left;
  teq_pkg::qtime_t    duration;
  teq_pkg::qtime_t    elapsed;
  teq_pkg::tag_t      out_object;
  teq_pkg::tag_t      out_payload;
  teq_pkg::removed_t  removed_count;
  logic               last;

  modport source (output valid, status, result_id, pending, time_left, duration, elapsed,
                  out_object, out_payload, removed_count, last, input ready);
  modport sink (input valid, status, result_id, pending, time_left, duration, elapsed,
                out_object, out_payload, removed_count, last, output ready);
endinterface

>>> hw/rtl/timed_event_queue.sv
// ----------------------------------------------------------------------------
// timed_event_queue
// Time-ordered event queue kept sorted in a single-port-read entry memory.
// ----------------------------------------------------------------------------
// Walk: post steps down from the tail through the entries after the insert
// point; the other commands walk all stored entries.
// Throughput: one command at a time; one memory read and one write per cycle
// set the walk rate while no execute pop stalls, and a new command is taken
// only once the response of the last one has been registered.
// Execute delivers one popped entry per cycle unless the response stalls.
// Reset: empty queue, time zero, next sequence id one; no clearing pass.
module timed_event_queue (
  input  logic        clk,
  input  logic        rst,
  teq_cmd_if.sink     cmd,
  teq_rsp_if.source   rsp
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_POST   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    teq_pkg::status_t  status;
    teq_pkg::seq_t     result_id;
    logic              pending;
    teq_pkg::qtime_t   time_left;
    teq_pkg::qtime_t   duration;
    teq_pkg::qtime_t   elapsed;
    teq_pkg::tag_t     out_object;
    teq_pkg::tag_t     out_payload;
    teq_pkg::removed_t removed_count;
    logic              last;
  } result_t;

  state_t            state;
  teq_pkg::cnt_t     count;
  teq_pkg::qtime_t   cur_time;
  teq_pkg::seq_t     next_seq;

  teq_pkg::func_t    func_r;
  teq_pkg::qtime_t   tv_r;
  teq_pkg::seq_t     eid_r;
  teq_pkg::tag_t     obj_r;
  teq_pkg::tag_t     pay_r;
  teq_pkg::qtime_t   post_t;
  teq_pkg::seq_t     post_id;

  teq_pkg::cnt_t     i;
  teq_pkg::cnt_t     cnt;
  logic              rv;
  teq_pkg::idx_t     ridx;
  logic              found;
  logic              run;
  logic              hold_valid;
  teq_pkg::entry_t   hold;
  result_t           res;
  logic              o_valid;
  result_t           o_data;

  teq_pkg::entry_t   rdata;
  teq_pkg::entry_t   wdata;
  teq_pkg::idx_t     raddr;
  teq_pkg::idx_t     waddr;
  logic              re;
  logic              we;

  logic              out_free;
  logic              accept;
  logic              hit_seq;
  logic              hit_obj;
  logic              drop;
  logic              stall;
  logic              scan_issue;
  logic              scan_done;
  logic              post_place;
  logic              post_issue;
  teq_pkg::cnt_t     i_dec;
  teq_pkg::entry_t   new_entry;
  logic [32:0]       due_sum;

  function automatic result_t pop_result(teq_pkg::entry_t e, logic fin);
    result_t r;
    r             = '0;
    r.result_id   = e.seq;
    r.out_object  = e.object;
    r.out_payload = e.payload;
    r.last        = fin;
    return r;
  endfunction

  teq_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free  = !o_valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign due_sum   = {1'b0, cur_time} + {1'b0, cmd.time_value};
  assign i_dec     = i - 1'b1;

  always_comb begin
    hit_seq = (rdata.seq == eid_r);
    hit_obj = (rdata.object == obj_r);
    unique case (func_r)
      teq_pkg::FN_CANCEL_ID:  drop = !found && hit_seq;
      teq_pkg::FN_CANCEL_OBJ: drop = hit_obj;
      teq_pkg::FN_EXEC:       drop = run && rdata.ready && (32'(cnt) < teq_pkg::MAX_POPS);
      default:                drop = 1'b0;
    endcase

    // A pop waits while the previous pop cannot leave.
    stall      = (state == S_SCAN) && rv && drop && (func_r == teq_pkg::FN_EXEC)
                 && hold_valid && !out_free;
    scan_issue = (state == S_SCAN) && !stall && (i < count);
    scan_done  = (state == S_SCAN) && !rv && !(i < count);

    post_place = (state == S_POST) && (rv ? !(rdata.due > post_t) : (i == '0));
    post_issue = (state == S_POST) && !post_place && (i != '0);

    new_entry  = '{due: post_t, start: cur_time, seq: post_id, object: obj_r,
                   payload: pay_r, ready: 1'b0};

    re    = scan_issue || post_issue;
    raddr = scan_issue ? i[teq_pkg::IDX_W-1:0] : i_dec[teq_pkg::IDX_W-1:0];

    we    = 1'b0;
    waddr = ridx;
    wdata = rdata;
    if (state == S_SCAN) begin
      // Compact survivors toward the head, closing gaps left by drops.
      we          = rv && !stall && !drop && (func_r != teq_pkg::FN_QUERY);
      waddr       = ridx - cnt[teq_pkg::IDX_W-1:0];
      wdata.ready = rdata.ready
                    || ((func_r == teq_pkg::FN_ADVANCE) && (rdata.due <= tv_r));
    end else if (state == S_POST) begin
      // Walk down from the tail, shifting later entries up by one.
      we    = 1'b1;
      waddr = rv ? (ridx + 1'b1) : '0;
      wdata = (rv && !post_place) ? rdata : new_entry;
      if (!rv && !post_place) begin
        we = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      cur_time   <= '0;
      next_seq   <= 32'd1;
      o_valid    <= 1'b0;
      rv         <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (o_valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      if (!stall) begin
        rv   <= re;
        ridx <= raddr;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_r     <= cmd.func;
            tv_r       <= cmd.time_value;
            eid_r      <= cmd.event_id;
            obj_r      <= cmd.object_id;
            pay_r      <= cmd.payload_handle;
            cnt        <= '0;
            found      <= 1'b0;
            run        <= 1'b1;
            hold_valid <= 1'b0;
            res        <= '0;
            i          <= '0;
            unique case (cmd.func)
              teq_pkg::FN_POST: begin
                if (count == teq_pkg::CNT_W'(teq_pkg::QUEUE_DEPTH)) begin
                  res.status <= teq_pkg::ST_FULL;
                  state      <= S_FINISH;
                end else begin
                  post_t   <= due_sum[32] ? '1 : due_sum[31:0];
                  post_id  <= next_seq;
                  next_seq <= (next_seq == '1) ? 32'd1 : next_seq + 32'd1;
                  i        <= count;
                  state    <= S_POST;
                end
              end
              teq_pkg::FN_CANCEL_ID, teq_pkg::FN_CANCEL_OBJ, teq_pkg::FN_EXEC: begin
                state <= S_SCAN;
              end
              teq_pkg::FN_QUERY: begin
                res.status <= teq_pkg::ST_NOT_FOUND;
                state      <= S_SCAN;
              end
              teq_pkg::FN_ADVANCE: begin
                if (cmd.time_value < cur_time) begin
                  res.status <= teq_pkg::ST_PAST;
                  state      <= S_FINISH;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        S_SCAN: begin
          if (!stall) begin
            if (scan_issue) begin
              i <= i + 1'b1;
            end
            if (rv) begin
              if ((func_r == teq_pkg::FN_QUERY) && !found && hit_seq) begin
                found         <= 1'b1;
                res.status    <= teq_pkg::ST_OK;
                res.pending   <= 1'b1;
                res.time_left <= (rdata.due > cur_time) ? rdata.due - cur_time : '0;
                res.duration  <= (rdata.due >= rdata.start) ? rdata.due - rdata.start : '0;
                res.elapsed   <= (cur_time >= rdata.start) ? cur_time - rdata.start : '0;
              end
              if ((func_r == teq_pkg::FN_CANCEL_ID) && drop) begin
                found <= 1'b1;
              end
              if (func_r == teq_pkg::FN_EXEC) begin
                if (drop) begin
                  hold       <= rdata;
                  hold_valid <= 1'b1;
                  if (hold_valid) begin
                    o_valid <= 1'b1;
                    o_data  <= pop_result(hold, 1'b0);
                  end
                end else begin
                  run <= 1'b0;
                end
              end
              if (drop) begin
                cnt <= cnt + 1'b1;
              end
            end
            if (scan_done) begin
              count <= count - cnt;
              state <= S_FINISH;
              unique case (func_r)
                teq_pkg::FN_CANCEL_ID: begin
                  res.status        <= found ? teq_pkg::ST_OK : teq_pkg::ST_NOT_FOUND;
                  res.removed_count <= found ? 5'd1 : 5'd0;
                end
                teq_pkg::FN_CANCEL_OBJ: begin
                  res.status        <= (cnt != '0) ? teq_pkg::ST_OK : teq_pkg::ST_NOT_FOUND;
                  res.removed_count <= (32'(cnt) > 31) ? 5'd31 : 5'(cnt);
                end
                teq_pkg::FN_ADVANCE: cur_time <= tv_r;
                teq_pkg::FN_EXEC: begin
                  if (cnt == '0) begin
                    res.status <= teq_pkg::ST_NONE_READY;
                  end
                end
                default: ;
              endcase
            end
          end
        end

        S_POST: begin
          if (post_issue) begin
            i <= i_dec;
          end
          if (post_place) begin
            count         <= count + 1'b1;
            res.result_id <= post_id;
            state         <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            o_valid <= 1'b1;
            if ((func_r == teq_pkg::FN_EXEC) && hold_valid) begin
              o_data <= pop_result(hold, 1'b1);
            end else begin
              o_data      <= res;
              o_data.last <= 1'b1;
            end
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.status        = o_data.status;
  assign rsp.result_id     = o_data.result_id;
  assign rsp.pending       = o_data.pending;
  assign rsp.time_left     = o_data.time_left;
  assign rsp.duration      = o_data.duration;
  assign rsp.elapsed       = o_data.elapsed;
  assign rsp.out_object    = o_data.out_object;
  assign rsp.out_payload   = o_data.out_payload;
  assign rsp.removed_count = o_data.removed_count;
  assign rsp.last          = o_data.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= teq_pkg::CNT_W'(teq_pkg::QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_seq_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_seq != '0)
    else $error("sequence id zero would be issued");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> cur_time >= $past(cur_time))
    else $error("current time moved backward");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("read and write hit the same slot");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && rv) |-> (teq_pkg::CNT_W'(ridx) < count))
    else $error("scan read beyond stored entries");

endmodule

>>> hw/rtl/teq_mem.sv
// ----------------------------------------------------------------------------
// teq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module teq_mem (
  input  logic              clk,
  input  logic              we,
  input  teq_pkg::idx_t     waddr,
  input  teq_pkg::entry_t   wdata,
  input  logic              re,
  input  teq_pkg::idx_t     raddr,
  output teq_pkg::entry_t   rdata
);

  teq_pkg::entry_t mem [teq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/teq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// teq_checker
// Watches both channels of the timed event queue, keeps a shadow of the
// sorted entry list and compares every response transfer in order.
// ----------------------------------------------------------------------------
module teq_checker
  import teq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  teq_cmd_if   cmd,
  teq_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding,
  output int   pops_seen,
  output int   queries_hit
);

  typedef struct packed {
    status_t  status;
    seq_t     result_id;
    logic     pending;
    qtime_t   time_left;
    qtime_t   duration;
    qtime_t   elapsed;
    tag_t     out_object;
    tag_t     out_payload;
    removed_t removed_count;
    logic     last;
  } response_t;

  entry_t    shadow_q[$];
  qtime_t    now_time;
  seq_t      seq_next;
  response_t expected_rsp[$];

  function automatic response_t blank_rsp();
    response_t r;
    r = '0;
    return r;
  endfunction

  function automatic int find_by_seq(seq_t id);
    for (int i = 0; i < shadow_q.size(); i++)
      if (shadow_q[i].seq == id) return i;
    return -1;
  endfunction

  task automatic predict_command(func_t fn, qtime_t tv, seq_t eid, tag_t obj, tag_t pay);
    response_t r;
    entry_t    e;
    qtime_t    due;
    int        pos;
    int        cnt;
    int        idx;
    r = blank_rsp();
    r.last = 1'b1;
    case (fn)
      FN_POST: begin
        if (shadow_q.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          due = now_time + tv;
          if (due < now_time) due = 32'hFFFF_FFFF;
          e = '0;
          e.due = due;
          e.start = now_time;
          e.seq = seq_next;
          e.object = obj;
          e.payload = pay;
          r.result_id = seq_next;
          seq_next = seq_next + 32'd1;
          if (seq_next == 0) seq_next = 32'd1;
          pos = 0;
          while (pos < shadow_q.size() && shadow_q[pos].due <= due) pos++;
          shadow_q.insert(pos, e);
        end
        expected_rsp.push_back(r);
      end
      FN_CANCEL_ID: begin
        idx = find_by_seq(eid);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          shadow_q.delete(idx);
          r.removed_count = 5'd1;
        end
        expected_rsp.push_back(r);
      end
      FN_CANCEL_OBJ: begin
        cnt = 0;
        idx = 0;
        while (idx < shadow_q.size()) begin
          if (shadow_q[idx].object == obj) begin
            shadow_q.delete(idx);
            cnt++;
          end else begin
            idx++;
          end
        end
        r.status = (cnt != 0) ? ST_OK : ST_NOT_FOUND;
        r.removed_count = (cnt > 31) ? 5'd31 : removed_t'(cnt);
        expected_rsp.push_back(r);
      end
      FN_QUERY: begin
        idx = find_by_seq(eid);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          e = shadow_q[idx];
          r.pending = 1'b1;
          r.time_left = (e.due > now_time) ? e.due - now_time : '0;
          r.duration = (e.due >= e.start) ? e.due - e.start : '0;
          r.elapsed = (now_time >= e.start) ? now_time - e.start : '0;
          queries_hit++;
        end
        expected_rsp.push_back(r);
      end
      FN_ADVANCE: begin
        if (tv < now_time) begin
          r.status = ST_PAST;
        end else begin
          for (int i = 0; i < shadow_q.size() && shadow_q[i].due <= tv; i++)
            shadow_q[i].ready = 1'b1;
          now_time = tv;
        end
        expected_rsp.push_back(r);
      end
      FN_EXEC: begin
        cnt = 0;
        while (cnt < MAX_POPS && shadow_q.size() > 0 && shadow_q[0].ready) begin
          r = blank_rsp();
          r.result_id = shadow_q[0].seq;
          r.out_object = shadow_q[0].object;
          r.out_payload = shadow_q[0].payload;
          r.last = (cnt + 1 == MAX_POPS) || shadow_q.size() == 1 || !shadow_q[1].ready;
          void'(shadow_q.pop_front());
          expected_rsp.push_back(r);
          cnt++;
        end
        if (cnt == 0) begin
          r = blank_rsp();
          r.status = ST_NONE_READY;
          r.last = 1'b1;
          expected_rsp.push_back(r);
        end
        pops_seen += cnt;
      end
      default: expected_rsp.push_back(r);
    endcase
  endtask

  task automatic compare_response();
    response_t got;
    response_t want;
    got.status = rsp.status;
    got.result_id = rsp.result_id;
    got.pending = rsp.pending;
    got.time_left = rsp.time_left;
    got.duration = rsp.duration;
    got.elapsed = rsp.elapsed;
    got.out_object = rsp.out_object;
    got.out_payload = rsp.out_payload;
    got.removed_count = rsp.removed_count;
    got.last = rsp.last;
    if (expected_rsp.size() == 0) begin
      $display("%0t: unexpected response, expected none, actual %p", $time, got);
      fail_count++;
    end else begin
      want = expected_rsp.pop_front();
      if (got !== want) begin
        $display("%0t: response mismatch, expected %p, actual %p", $time, want, got);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_q.delete();
      expected_rsp.delete();
      now_time = '0;
      seq_next = 32'd1;
      fail_count = 0;
      pops_seen = 0;
      queries_hit = 0;
    end else begin
      // compare first: a response never belongs to a command taken this edge
      if (rsp.valid && rsp.ready) compare_response();
      if (cmd.valid && cmd.ready)
        predict_command(cmd.func, cmd.time_value, cmd.event_id, cmd.object_id,
                        cmd.payload_handle);
    end
    outstanding <= expected_rsp.size();
  end

endmodule

>>> tb/tb_timed_event_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_event_queue
// Directed and random command streams into the timed event queue, with
// random idle bursts on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_timed_event_queue;
  import teq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   outstanding;
  int   pops_seen;
  int   queries_hit;
  int   sent_count = 0;
  bit   calm = 1'b0;

  teq_cmd_if cmd ();
  teq_rsp_if rsp ();

  timed_event_queue dut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  teq_checker checker_i (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp), .fail_count(fail_count),
    .outstanding(outstanding), .pops_seen(pops_seen), .queries_hit(queries_hit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.func = FN_POST;
    cmd.time_value = '0;
    cmd.event_id = '0;
    cmd.object_id = '0;
    cmd.payload_handle = '0;
    rsp.ready = 1'b0;
  end

  // response side stalls in bursts, never in the calm tail
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 17);
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send(func_t fn, qtime_t tv, seq_t eid, tag_t obj, tag_t pay);
    cmd.valid <= 1'b1;
    cmd.func <= fn;
    cmd.time_value <= tv;
    cmd.event_id <= eid;
    cmd.object_id <= obj;
    cmd.payload_handle <= pay;
    @(posedge clk iff cmd.ready);
    sent_count++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // pick an id near recent ones so cancels and queries mostly hit
  function automatic seq_t near_id();
    seq_t base;
    base = checker_i.seq_next;
    return (base > 20) ? base - $urandom_range(1, 20) : $urandom_range(0, 20);
  endfunction

  task automatic random_command();
    int    pick;
    qtime_t cur;
    cur = checker_i.now_time;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      send(FN_POST, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h4_0000),
           '0, tag_t'($urandom_range(0, 7)), tag_t'($urandom));
    else if (pick < 45)
      send(FN_CANCEL_ID, '0, ($urandom_range(0, 4) == 0) ? $urandom : near_id(), '0, '0);
    else if (pick < 50)
      send(FN_CANCEL_OBJ, '0, '0,
           tag_t'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 7)), '0);
    else if (pick < 62)
      send(FN_QUERY, '0, near_id(), '0, '0);
    else if (pick < 78)
      send(FN_ADVANCE, ($urandom_range(0, 9) == 0) ? $urandom :
           cur + $urandom_range(0, 32'h3_0000), '0, '0, '0);
    else if (pick < 97)
      send(FN_EXEC, $urandom, $urandom, tag_t'($urandom), tag_t'($urandom));
    else
      send(func_t'($urandom_range(6, 7)), $urandom, $urandom, tag_t'($urandom),
           tag_t'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty-queue cases, ordering ties, saturation, full queue
    send(FN_EXEC, '0, '0, '0, '0);
    send(FN_QUERY, '0, 32'd1, '0, '0);
    send(FN_CANCEL_ID, '0, 32'hFFFF_FFFF, '0, '0);
    send(FN_CANCEL_OBJ, '0, '0, 16'hFFFF, '0);
    send(func_t'(6), 32'hFFFF_FFFF, '1, '1, '1);
    send(func_t'(7), '0, '0, '0, '0);
    for (int i = 0; i < 17; i++)
      send(FN_POST, (i % 3 == 0) ? 32'h1_0000 : 32'hFFFF_FFFF, '0,
           (i % 2) ? 16'hFFFF : 16'h0000, (i % 2) ? 16'h0000 : 16'hFFFF);
    send(FN_QUERY, '0, 32'd2, '0, '0);
    send(FN_ADVANCE, 32'h8000_0000, '0, '0, '0);
    send(FN_ADVANCE, 32'h0000_0001, '0, '0, '0);
    send(FN_QUERY, '0, 32'd1, '0, '0);
    send(FN_EXEC, '0, '0, '0, '0);
    send(FN_ADVANCE, 32'hFFFF_FFFF, '0, '0, '0);
    send(FN_POST, 32'h1234_5678, '0, 16'h00AA, 16'h5555);
    send(FN_CANCEL_OBJ, '0, '0, 16'hFFFF, '0);
    send(FN_EXEC, '0, '0, '0, '0);
    send(FN_EXEC, '0, '0, '0, '0);
    // hold off until the queue has answered everything
    drain();
    for (int n = 0; n < 427; n++) begin
      if (n == 200) drain();
      if (n == 370) calm = 1'b1;
      random_command();
    end
    drain();
    $display("Covered %0d commands; %0d entries popped, %0d queries found an entry.",
             sent_count, pops_seen, queries_hit);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> timed_event_queue.f
hw/rtl/teq_pkg.sv
hw/rtl/teq_if.sv
hw/rtl/teq_mem.sv
hw/rtl/timed_event_queue.sv
tb/teq_checker.sv
tb/tb_timed_event_queue.sv
